// File: hdl/bts_pkg.sv
// Shared types and constants for the bilinear texture sampler.
// No dependencies; all files but the two interfaces import this package.
`default_nettype none
package bts_pkg;

    localparam int TEX_AW    = 8;              // texel index bits per axis
    localparam int STORE_AW  = 2 * TEX_AW;     // texel store address bits
    localparam int FRAC      = 8;              // fraction bits of a coordinate
    localparam int COORD_W   = 32;
    localparam int INT_W     = COORD_W - FRAC; // integer part bits
    localparam int DIV_STEPS = INT_W;          // one quotient bit per stage
    localparam int WT_W      = 2 * FRAC + 1;   // blend weight, up to 2^16
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int TAPS      = 4;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        CFG_TEX_WIDTH  = 3'd0,
        CFG_TEX_HEIGHT = 3'd1,
        CFG_H_WRAP     = 3'd2,
        CFG_V_WRAP     = 3'd3,
        CFG_NEAREST    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WRAP_NONE    = 2'd0,
        WRAP_PAD     = 2'd1,
        WRAP_REPEAT  = 2'd2,
        WRAP_REFLECT = 2'd3
    } t_wrap;

    // Effective configuration seen by the pipeline
    typedef struct packed {
        logic [8:0] n_w;
        logic [8:0] n_h;
        t_wrap      h_wrap;
        t_wrap      v_wrap;
        logic       nearest;
    } t_cfg;

    // One queue entry handed from front to back
    typedef struct packed {
        logic                              is_smp;
        logic [STORE_AW-1:0]               ld_addr;
        logic [31:0]                       ld_data;
        logic [TAPS-1:0][STORE_AW-1:0]     addr;
        logic [TAPS-1:0][WT_W-1:0]         wt;
    } t_qent;

endpackage
`default_nettype wire

// File: hdl/bts_in_if.sv
// Input channel of the texture sampler: load and sample transactions.
// Depends on nothing.
`default_nettype none
interface bts_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         load_col;
    logic [7:0]         load_row;
    logic [7:0]         texel_red;
    logic [7:0]         texel_green;
    logic [7:0]         texel_blue;
    logic [7:0]         texel_alpha;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;

    modport source (output valid, opcode, load_col, load_row, texel_red, texel_green,
                    texel_blue, texel_alpha, sample_x, sample_y, input ready);
    modport sink   (input valid, opcode, load_col, load_row, texel_red, texel_green,
                    texel_blue, texel_alpha, sample_x, sample_y, output ready);
endinterface
`default_nettype wire

// File: hdl/bts_out_if.sv
// Output channel of the texture sampler: one RGBA result per sample.
// Depends on nothing.
`default_nettype none
interface bts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface
`default_nettype wire

// File: hdl/bts_front.sv
// Front end: floor, wrap (pipelined modulo) and weights for each transaction.
// Depends on bts_pkg and bts_in_if.
`default_nettype none
module bts_front
    import bts_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    bts_in_if.sink     i_smp,
    input  wire logic  i_q_full,
    output logic       o_push,
    output t_qent      o_ent
);

    typedef struct packed {
        logic              neg;
        logic              okn0;
        logic              okn1;
        logic [7:0]        lo0;
        logic [7:0]        lo1;
        logic [7:0]        pad0;
        logic [7:0]        pad1;
        logic [INT_W-1:0]  a;
        logic [7:0]        rem;
        logic              q;
    } t_ax_st;

    typedef struct packed {
        logic                       ok0;
        logic                       ok1;
        logic [7:0]                 idx0;
        logic [7:0]                 idx1;
    } t_ax_res;

    typedef struct packed {
        logic                       is_smp;
        logic [STORE_AW-1:0]        ld_addr;
        logic [31:0]                ld_data;
        logic [TAPS-1:0][WT_W-1:0]  wt;
        t_ax_st                     ax;
        t_ax_st                     ay;
    } t_fst;

    function automatic t_ax_st ax_init(logic [INT_W-1:0] li, logic [8:0] n);
        t_ax_st            s;
        logic [INT_W:0]    c0;
        logic [INT_W:0]    c1;
        logic [INT_W:0]    nn;
        logic [INT_W:0]    na;
        c0 = {li[INT_W-1], li};
        c1 = c0 + (INT_W+1)'(1);
        nn = (INT_W+1)'(n);
        na = -c0;
        s.neg  = c0[INT_W];
        s.okn0 = !c0[INT_W] && (c0 < nn);
        s.okn1 = !c1[INT_W] && (c1 < nn);
        s.lo0  = c0[7:0];
        s.lo1  = c1[7:0];
        s.pad0 = c0[INT_W] ? 8'd0 : ((c0 >= nn) ? 8'(n - 9'd1) : c0[7:0]);
        s.pad1 = c1[INT_W] ? 8'd0 : ((c1 >= nn) ? 8'(n - 9'd1) : c1[7:0]);
        s.a    = c0[INT_W] ? na[INT_W-1:0] : c0[INT_W-1:0];
        s.rem  = 8'd0;
        s.q    = 1'b0;
        return s;
    endfunction

    function automatic t_ax_st ax_step(t_ax_st s, logic b, logic [8:0] n);
        t_ax_st     r;
        logic [8:0] t;
        r = s;
        t = {s.rem, b};
        if (t >= n) begin
            r.rem = 8'(t - n);
            r.q   = 1'b1;
        end else begin
            r.rem = t[7:0];
            r.q   = 1'b0;
        end
        return r;
    endfunction

    function automatic t_ax_res ax_fin(t_ax_st s, logic [8:0] n, t_wrap mode);
        t_ax_res    r;
        logic [7:0] m;
        logic       par;
        logic [8:0] m1p;
        logic       wr1;
        logic [7:0] m1;
        logic       par1;
        logic [7:0] nm1;
        if (!s.neg) begin
            m   = s.rem;
            par = s.q;
        end else if (s.rem == 8'd0) begin
            m   = 8'd0;
            par = s.q;
        end else begin
            m   = 8'(n - {1'b0, s.rem});
            par = !s.q;
        end
        m1p  = {1'b0, m} + 9'd1;
        wr1  = (m1p == n);
        m1   = wr1 ? 8'd0 : m1p[7:0];
        par1 = par ^ wr1;
        nm1  = 8'(n - 9'd1);
        r.ok0 = 1'b1;
        r.ok1 = 1'b1;
        case (mode)
            WRAP_PAD: begin
                r.idx0 = s.pad0;
                r.idx1 = s.pad1;
            end
            WRAP_REPEAT: begin
                r.idx0 = m;
                r.idx1 = m1;
            end
            WRAP_REFLECT: begin
                r.idx0 = par  ? 8'(nm1 - m)  : m;
                r.idx1 = par1 ? 8'(nm1 - m1) : m1;
            end
            default: begin
                r.ok0  = s.okn0;
                r.ok1  = s.okn1;
                r.idx0 = s.lo0;
                r.idx1 = s.lo1;
            end
        endcase
        return r;
    endfunction

    logic    en;
    logic    r_v  [0:DIV_STEPS];
    t_fst    r_st [0:DIV_STEPS];
    t_fst    n_st [0:DIV_STEPS];
    logic    r_vo;
    t_qent   r_ent;
    t_qent   n_ent;

    // Hold the whole front while the finished entry cannot enter the queue
    assign en          = !r_vo || !i_q_full;
    assign i_smp.ready = en;
    assign o_push      = r_vo && !i_q_full;
    assign o_ent       = r_ent;

    always_comb begin
        logic [8:0]  gx;
        logic [8:0]  gy;
        logic [17:0] p00;
        logic [17:0] p10;
        logic [17:0] p01;
        logic [17:0] p11;
        gx = 9'd256 - {1'b0, i_smp.sample_x[FRAC-1:0]};
        gy = 9'd256 - {1'b0, i_smp.sample_y[FRAC-1:0]};
        p00 = gx * gy;
        p10 = {1'b0, i_smp.sample_x[FRAC-1:0]} * gy;
        p01 = gx * {1'b0, i_smp.sample_y[FRAC-1:0]};
        p11 = {1'b0, i_smp.sample_x[FRAC-1:0]} * {1'b0, i_smp.sample_y[FRAC-1:0]};
        n_st[0].is_smp  = (i_smp.opcode == OP_SAMPLE);
        n_st[0].ld_addr = {i_smp.load_row, i_smp.load_col};
        n_st[0].ld_data = {i_smp.texel_alpha, i_smp.texel_blue,
                           i_smp.texel_green, i_smp.texel_red};
        if (i_cfg.nearest) begin
            n_st[0].wt[0] = WT_W'(1 << (2 * FRAC));
            n_st[0].wt[1] = '0;
            n_st[0].wt[2] = '0;
            n_st[0].wt[3] = '0;
        end else begin
            n_st[0].wt[0] = p00[WT_W-1:0];
            n_st[0].wt[1] = p10[WT_W-1:0];
            n_st[0].wt[2] = p01[WT_W-1:0];
            n_st[0].wt[3] = p11[WT_W-1:0];
        end
        n_st[0].ax = ax_init(i_smp.sample_x[COORD_W-1:FRAC], i_cfg.n_w);
        n_st[0].ay = ax_init(i_smp.sample_y[COORD_W-1:FRAC], i_cfg.n_h);
        // One quotient bit per stage, MSB first
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_st[k]    = r_st[k-1];
            n_st[k].ax = ax_step(r_st[k-1].ax, r_st[k-1].ax.a[DIV_STEPS-k], i_cfg.n_w);
            n_st[k].ay = ax_step(r_st[k-1].ay, r_st[k-1].ay.a[DIV_STEPS-k], i_cfg.n_h);
        end
    end

    always_comb begin
        t_ax_res rx;
        t_ax_res ry;
        rx = ax_fin(r_st[DIV_STEPS].ax, i_cfg.n_w, i_cfg.h_wrap);
        ry = ax_fin(r_st[DIV_STEPS].ay, i_cfg.n_h, i_cfg.v_wrap);
        n_ent.is_smp  = r_st[DIV_STEPS].is_smp;
        n_ent.ld_addr = r_st[DIV_STEPS].ld_addr;
        n_ent.ld_data = r_st[DIV_STEPS].ld_data;
        n_ent.addr[0] = {ry.idx0, rx.idx0};
        n_ent.addr[1] = {ry.idx0, rx.idx1};
        n_ent.addr[2] = {ry.idx1, rx.idx0};
        n_ent.addr[3] = {ry.idx1, rx.idx1};
        // Drop taps that fall outside under mode none
        n_ent.wt[0] = (rx.ok0 && ry.ok0) ? r_st[DIV_STEPS].wt[0] : '0;
        n_ent.wt[1] = (rx.ok1 && ry.ok0) ? r_st[DIV_STEPS].wt[1] : '0;
        n_ent.wt[2] = (rx.ok0 && ry.ok1) ? r_st[DIV_STEPS].wt[2] : '0;
        n_ent.wt[3] = (rx.ok1 && ry.ok1) ? r_st[DIV_STEPS].wt[3] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_v[k] <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_smp.valid;
            for (int k = 1; k <= DIV_STEPS; k++) r_v[k] <= r_v[k-1];
            r_vo <= r_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= DIV_STEPS; k++) r_st[k] <= n_st[k];
            r_ent <= n_ent;
        end
    end

endmodule
`default_nettype wire

// File: hdl/bts_queue.sv
// Short register queue between front and back end.
// Depends on bts_pkg.
`default_nettype none
module bts_queue
    import bts_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_ent,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_qent      o_ent
);

    t_qent             r_mem [0:Q_DEPTH-1];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              pop_ok;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_ent   = r_mem[r_rp];
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_AW'(1);
            if (pop_ok) r_rp <= r_rp + Q_AW'(1);
            if (i_push && !pop_ok)      r_cnt <= r_cnt + (Q_AW+1)'(1);
            else if (!i_push && pop_ok) r_cnt <= r_cnt - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_ent;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == (Q_AW+1)'(Q_DEPTH)) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// File: hdl/bts_back.sv
// Back end: texel store, four tap reads, blend and output register.
// Depends on bts_pkg and bts_out_if.
`default_nettype none
module bts_back
    import bts_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_qent i_ent,
    output logic       o_pop,
    bts_out_if.source  o_res
);

    localparam int PROD_W = WT_W + 8;

    logic [31:0] mem_a [0:(1<<STORE_AW)-1];
    logic [31:0] mem_b [0:(1<<STORE_AW)-1];

    logic                              en;
    logic                              r_v1;
    logic [TAPS-1:0][WT_W-1:0]         r_wt1;
    logic [TAPS-1:0][31:0]             r_rd;
    logic                              r_v2;
    logic [TAPS-1:0][3:0][PROD_W-1:0]  r_prod;
    logic                              r_ov;
    logic [3:0][7:0]                   r_rgba;
    logic [3:0][7:0]                   n_rgba;

    assign en    = !r_ov || o_res.ready;
    assign o_pop = en && !i_empty;

    // Two copies of the store, two read ports each
    always_ff @(posedge i_clk) begin
        if (o_pop && !i_ent.is_smp) begin
            mem_a[i_ent.ld_addr] <= i_ent.ld_data;
            mem_b[i_ent.ld_addr] <= i_ent.ld_data;
        end
        if (en) begin
            r_rd[0] <= mem_a[i_ent.addr[0]];
            r_rd[1] <= mem_a[i_ent.addr[1]];
            r_rd[2] <= mem_b[i_ent.addr[2]];
            r_rd[3] <= mem_b[i_ent.addr[3]];
        end
    end

    always_comb begin
        logic [PROD_W+1:0] s;
        for (int c = 0; c < 4; c++) begin
            s = '0;
            for (int t = 0; t < TAPS; t++) s = s + (PROD_W+2)'(r_prod[t][c]);
            n_rgba[c] = s[2*FRAC +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= o_pop && i_ent.is_smp;
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    // A dropped tap may point at a never-loaded entry; keep its data out of the sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wt1 <= i_ent.wt;
            for (int t = 0; t < TAPS; t++)
                for (int c = 0; c < 4; c++)
                    r_prod[t][c] <= (r_wt1[t] == '0) ? '0 : r_wt1[t] * r_rd[t][8*c +: 8];
            r_rgba <= n_rgba;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.out_red   = r_rgba[0];
    assign o_res.out_green = r_rgba[1];
    assign o_res.out_blue  = r_rgba[2];
    assign o_res.out_alpha = r_rgba[3];

endmodule
`default_nettype wire

// File: hdl/bilinear_texture_sampler_wrap_top.sv
// Top level of the bilinear texture sampler with per-axis wrap modes.
// Depends on bts_pkg, bts_in_if, bts_out_if, bts_front, bts_queue, bts_back.
//
//  channel  dir  transaction
//  i_smp    in   load texel (opcode 0) or sample at 24.8 coordinate (opcode 1)
//  o_res    out  one RGBA color per sample, nothing per load
//  i_cfg_*  in   register write: index, 9-bit data, no read-back
//
// One transaction per cycle sustained; the front, queue and back each hold
// only when the next part is full. A sample's result passes through 26 front
// stages (floor and weights, loaded at the accepting edge, then one quotient
// bit per stage of the wrap modulo, then wrap select), the queue register, a
// store read, a multiply and an add stage. Reset clears only control state;
// the texel store holds garbage until loaded and needs no clearing pass.
`default_nettype none
module bilinear_texture_sampler_wrap_top
    import bts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [8:0] i_cfg_data,
    bts_in_if.sink          i_smp,
    bts_out_if.source       o_res
);

    logic [8:0] r_tex_w;
    logic [8:0] r_tex_h;
    t_wrap      r_h_wrap;
    t_wrap      r_v_wrap;
    logic       r_nearest;
    t_cfg       cfg;

    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    t_qent f_ent;
    t_qent q_ent;

    // Register writes; an unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w   <= 9'd256;
            r_tex_h   <= 9'd256;
            r_h_wrap  <= WRAP_NONE;
            r_v_wrap  <= WRAP_NONE;
            r_nearest <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEX_WIDTH:  r_tex_w   <= i_cfg_data;
                CFG_TEX_HEIGHT: r_tex_h   <= i_cfg_data;
                CFG_H_WRAP:     r_h_wrap  <= t_wrap'(i_cfg_data[1:0]);
                CFG_V_WRAP:     r_v_wrap  <= t_wrap'(i_cfg_data[1:0]);
                CFG_NEAREST:    r_nearest <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Size zero acts as one, anything above the store size saturates
    always_comb begin
        cfg.n_w     = (r_tex_w == 9'd0) ? 9'd1 : ((r_tex_w > 9'd256) ? 9'd256 : r_tex_w);
        cfg.n_h     = (r_tex_h == 9'd0) ? 9'd1 : ((r_tex_h > 9'd256) ? 9'd256 : r_tex_h);
        cfg.h_wrap  = r_h_wrap;
        cfg.v_wrap  = r_v_wrap;
        cfg.nearest = r_nearest;
    end

    bts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_smp    (i_smp),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_ent    (f_ent)
    );

    bts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (f_ent),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_ent   (q_ent)
    );

    bts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_ent   (q_ent),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for the bilinear texture sampler: load/sample stimulus, RGBA prediction and check.
// Depends on bts_pkg, bts_in_if, bts_out_if and bilinear_texture_sampler_wrap_top.
`timescale 1ns / 1ps
module tb_top;
    import bts_pkg::*;

    typedef struct {
        logic               opcode;
        logic [7:0]         col;
        logic [7:0]         row;
        logic [31:0]        texel;   // r | g<<8 | b<<16 | a<<24
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } t_item;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [8:0] i_cfg_data;

    bts_in_if  smp_if ();
    bts_out_if res_if ();

    bilinear_texture_sampler_wrap_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp_if.sink),
        .o_res      (res_if.source)
    );

    // Predictor state: shadow store, written-flags and registers
    logic [31:0] shadow_texels [0:65535];
    bit          texel_loaded  [0:65535];
    int unsigned cfg_w, cfg_h;
    t_wrap       cfg_hw, cfg_vw;
    bit          cfg_near;

    t_item       pending_items[$];
    logic [31:0] expected_colors[$];
    int          error_count;
    bit          idle_enable;
    bit          in_fired;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Map one coordinate onto the texture by wrap mode; return 0 for transparent
    function automatic bit map_axis(input longint c, input int unsigned n, input t_wrap mode,
                                    output int unsigned idx);
        longint nn, m, q;
        nn = n;
        m = c % nn;
        if (m < 0) m += nn;
        idx = 0;
        case (mode)
            WRAP_PAD: begin
                if (c < 0) c = 0;
                if (c > nn - 1) c = nn - 1;
                idx = 32'(c);
                return 1;
            end
            WRAP_REPEAT: begin
                idx = 32'(m);
                return 1;
            end
            WRAP_REFLECT: begin
                q = (c - m) / nn;
                idx = q[0] ? 32'(nn - 1 - m) : 32'(m);
                return 1;
            end
            default: begin
                if (c < 0 || c >= nn) return 0;
                idx = 32'(c);
                return 1;
            end
        endcase
    endfunction

    function automatic logic [31:0] texel_at(input longint x, input longint y);
        int unsigned ix, iy;
        if (!map_axis(x, cfg_w, cfg_hw, ix)) return 32'd0;
        if (!map_axis(y, cfg_h, cfg_vw, iy)) return 32'd0;
        if (!texel_loaded[iy * 256 + ix]) begin
            $display("%0t: stimulus reads unloaded texel (%0d,%0d)", $realtime, ix, iy);
            error_count++;
        end
        return shadow_texels[iy * 256 + ix];
    endfunction

    function automatic logic [31:0] sample_color(input logic signed [31:0] sx,
                                                 input logic signed [31:0] sy);
        longint      lx, ly;
        int unsigned fx, fy, gx, gy;
        int unsigned acc [4];
        logic [31:0] t [4];
        int unsigned wts [4];
        logic [31:0] res;
        lx = longint'(sx) >>> 8;
        ly = longint'(sy) >>> 8;
        if (cfg_near) return texel_at(lx, ly);
        fx = 32'(sx[7:0]);
        fy = 32'(sy[7:0]);
        gx = 256 - fx;
        gy = 256 - fy;
        t[0] = texel_at(lx, ly);
        t[1] = texel_at(lx + 1, ly);
        t[2] = texel_at(lx, ly + 1);
        t[3] = texel_at(lx + 1, ly + 1);
        wts[0] = gx * gy; wts[1] = fx * gy; wts[2] = gx * fy; wts[3] = fx * fy;
        for (int k = 0; k < 4; k++) begin
            acc[k] = 0;
            for (int j = 0; j < 4; j++) acc[k] += wts[j] * t[j][8*k +: 8];
            res[8*k +: 8] = 8'(acc[k] >> 16);
        end
        return res;
    endfunction

    // Retire the transaction accepted at this edge and predict its result
    always @(posedge i_clk) begin
        in_fired = i_rst_n && smp_if.valid && smp_if.ready;
        if (in_fired) begin
            t_item it;
            it = pending_items.pop_front();
            if (it.opcode == OP_LOAD) begin
                shadow_texels[{it.row, it.col}] = it.texel;
                texel_loaded[{it.row, it.col}] = 1;
            end else begin
                expected_colors.push_back(sample_color(it.sx, it.sy));
            end
        end
    end

    // Driver: present queued transactions at the falling edge; hold one that waits
    always @(negedge i_clk) begin
        if (!(smp_if.valid && !in_fired)) begin
            if (i_rst_n && pending_items.size() > 0 &&
                !(idle_enable && $urandom_range(99) < 10)) begin
                smp_if.valid       <= 1'b1;
                smp_if.opcode      <= pending_items[0].opcode;
                smp_if.load_col    <= pending_items[0].col;
                smp_if.load_row    <= pending_items[0].row;
                {smp_if.texel_alpha, smp_if.texel_blue, smp_if.texel_green, smp_if.texel_red}
                                   <= pending_items[0].texel;
                smp_if.sample_x    <= pending_items[0].sx;
                smp_if.sample_y    <= pending_items[0].sy;
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
        res_if.ready <= !(idle_enable && $urandom_range(99) < 10);
    end

    // Monitor: compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            logic [31:0] got, exp_c;
            got = {res_if.out_alpha, res_if.out_blue, res_if.out_green, res_if.out_red};
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                error_count++;
            end else begin
                exp_c = expected_colors.pop_front();
                for (int k = 0; k < 4; k++)
                    if (got[8*k +: 8] !== exp_c[8*k +: 8]) begin
                        $display("%0t: channel %0d expected %h actual %h",
                                 $realtime, k, exp_c[8*k +: 8], got[8*k +: 8]);
                        error_count++;
                    end
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[8:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TEX_WIDTH:  cfg_w = val == 0 ? 1 : (val > 256 ? 256 : val);
            CFG_TEX_HEIGHT: cfg_h = val == 0 ? 1 : (val > 256 ? 256 : val);
            CFG_H_WRAP:     cfg_hw = t_wrap'(val[1:0]);
            CFG_V_WRAP:     cfg_vw = t_wrap'(val[1:0]);
            default:        cfg_near = val[0];
        endcase
    endtask

    task automatic apply_setting(input int unsigned w, input int unsigned h, input t_wrap hw,
                                 input t_wrap vw, input bit near);
        write_reg(CFG_TEX_WIDTH, w);
        write_reg(CFG_TEX_HEIGHT, h);
        write_reg(CFG_H_WRAP, hw);
        write_reg(CFG_V_WRAP, vw);
        write_reg(CFG_NEAREST, near);
    endtask

    // Hold until every queued transaction and every result is through
    task automatic drain();
        wait (pending_items.size() == 0 && expected_colors.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic push_load(input int col, input int row, input logic [31:0] texel);
        t_item it;
        it.opcode = OP_LOAD;
        it.col = col; it.row = row; it.texel = texel;
        it.sx = $urandom; it.sy = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic push_sample(input logic signed [31:0] sx, input logic signed [31:0] sy);
        t_item it;
        it.opcode = OP_SAMPLE;
        it.col = $urandom; it.row = $urandom; it.texel = $urandom;
        it.sx = sx; it.sy = sy;
        pending_items.push_back(it);
    endtask

    // Fill the corner region that the texture sizes below can reach
    task automatic load_region(input int w, input int h, input bit extremes);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                push_load(c, r, extremes ? ((r + c) % 2 ? 32'hFFFF_FFFF : 32'h0) : $urandom);
    endtask

    // Random coordinate: mostly near the texture, sometimes anywhere
    function automatic logic signed [31:0] rand_coord(input int unsigned n);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return $urandom;
        if (sel == 1) return $urandom_range(1, 3) == 1 ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return $signed($urandom_range(0, 4 * n * 256)) - $signed(2 * n * 256);
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        smp_if.valid = 1'b0;
        smp_if.opcode = OP_LOAD;
        smp_if.load_col = '0; smp_if.load_row = '0;
        smp_if.texel_red = '0; smp_if.texel_green = '0;
        smp_if.texel_blue = '0; smp_if.texel_alpha = '0;
        smp_if.sample_x = '0; smp_if.sample_y = '0;
        res_if.ready = 1'b0;
        error_count = 0;
        idle_enable = 1'b0;
        in_fired = 1'b0;
        cfg_w = 256; cfg_h = 256; cfg_hw = WRAP_NONE; cfg_vw = WRAP_NONE; cfg_near = 0;
        for (int i = 0; i < 65536; i++) texel_loaded[i] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Checkerboard of all-ones and all-zeros; full-speed load, no idling
        load_region(16, 16, 1);
        drain();

        // Directed: coordinate extremes, each wrap mode, far outside with none/none
        apply_setting(16, 16, WRAP_NONE, WRAP_NONE, 0);
        push_sample(32'sh0000_0080, 32'sh0000_0080);
        push_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_sample(32'sh8000_0000, 32'sh8000_0000);
        push_sample(-32'sh80, -32'sh80);
        push_sample(32'sh0000_0F80, 32'sh0000_0FFF);
        push_sample(32'sh0000_04FF, 32'sh0000_0101);
        drain();
        apply_setting(1, 1, WRAP_PAD, WRAP_REPEAT, 1);
        push_sample(32'sh8000_0000, 32'sh7FFF_FFFF);
        push_sample(32'sh0000_0155, -32'sh155);
        drain();
        // Height above the store saturates; pad then reaches the last row
        load_region(1, 256, 1);
        drain();
        apply_setting(0, 511, WRAP_REFLECT, WRAP_PAD, 0);
        push_sample(32'sh8000_00FF, 32'sh7FFF_FF00);
        push_sample(-32'sh10080, 32'sh12345);
        drain();
        apply_setting(3, 5, WRAP_REFLECT, WRAP_REFLECT, 0);
        for (int i = -8; i < 8; i++) push_sample(i * 256 + 128, i * 300 + 77);
        drain();

        // Random phases: settings, partial reloads within the region, random samples
        idle_enable = 1'b1;
        load_region(16, 16, 0);
        drain();
        for (int ph = 0; ph < 12; ph++) begin
            int unsigned w, h;
            w = ph == 0 ? 16 : (ph == 1 ? 1 : $urandom_range(1, 16));
            h = ph == 0 ? 16 : (ph == 2 ? 1 : $urandom_range(1, 16));
            apply_setting(w, h, t_wrap'($urandom_range(3)), t_wrap'($urandom_range(3)),
                          $urandom_range(1));
            idle_enable = (ph != 5);
            for (int i = 0; i < 90; i++) begin
                if ($urandom_range(3) == 0)
                    push_load($urandom_range(15), $urandom_range(15), $urandom);
                else
                    push_sample(rand_coord(w), rand_coord(h));
            end
            drain();
        end
        if (error_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    // Run limit: far above the length of a correct run
    initial begin
        #1ms;
        $display("FAILURE");
        $finish;
    end
endmodule
